// ===== rtl/pcf_pkg.sv =====
// pcf_pkg: shared types and constants of the photo chunk framer
// used by every module under rtl; depends on nothing
`timescale 1ns / 1ps

package pcf_pkg;

  localparam int unsigned PayloadW  = 10;
  localparam int unsigned IndexW    = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);
  localparam int unsigned StepW     = 2;

  localparam logic [PayloadW-1:0] PayloadReset = PayloadW'(200);
  localparam logic [ByteW-1:0]    OrientReset  = '0;
  localparam logic [ByteW-1:0]    MarkerByte   = 8'hFF;

  localparam logic [CfgIdxW-1:0] CfgChunkPayload = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOrientation  = 2'd1;

  typedef enum logic [1:0] {
    JOB_MARKER,
    JOB_HDR,
    JOB_HDR_ORIENT,
    JOB_DATA
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic [IndexW-1:0] index;
    logic [ByteW-1:0]  orient;
    logic [ByteW-1:0]  data;
  } job_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             chunk_start;
    logic             is_marker;
    logic             run_last;
  } out_beat_t;

endpackage

// ===== rtl/photo_chunk_framer.sv =====
// photo_chunk_framer: top level, front end, job queue and byte back end
// depends on pcf_pkg, pcf_front, pcf_queue, pcf_back
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   input    | in_valid_i / in_stall_o | kind_i, data_byte_i
//   output   | out_valid_o/out_stall_i | out_byte_o, chunk_start_o, is_marker_o,
//            |                         | run_last_o
//   config   | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// the back end sends one byte per cycle while the output is not stalled: a data byte inside a chunk
// goes out as one byte, a chunk-opening byte as three or four (header bytes), end of photo as two
// the front end takes one transaction per cycle into a four-entry job queue
// and stalls only when the queue is full; the output register parts the sides
// an input transaction is written into the job queue, and its first output byte is then loaded into the output register
// reset clears index, fill, queue and output valid and loads register defaults
`timescale 1ns / 1ps

module photo_chunk_framer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pcf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [pcf_pkg::ByteW-1:0]    data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pcf_pkg::ByteW-1:0]    out_byte_o,
  output logic                         chunk_start_o,
  output logic                         is_marker_o,
  output logic                         run_last_o
);

  logic               push;
  pcf_pkg::job_t      push_job;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  pcf_pkg::job_t      q_head;
  pcf_pkg::out_beat_t beat;

  pcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  pcf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  pcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (beat)
  );

  assign out_byte_o    = beat.out_byte;
  assign chunk_start_o = beat.chunk_start;
  assign is_marker_o   = beat.is_marker;
  assign run_last_o    = beat.run_last;

endmodule

// ===== rtl/pcf_front.sv =====
// pcf_front: accepts input transactions, tracks chunk index and fill,
// holds the configuration registers and issues one job per transaction; uses pcf_pkg
`timescale 1ns / 1ps

module pcf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pcf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         kind_i,
  input  logic [pcf_pkg::ByteW-1:0]    data_byte_i,
  input  logic                         q_full_i,
  output logic                         in_stall_o,
  output logic                         push_o,
  output pcf_pkg::job_t                push_job_o
);

  logic [pcf_pkg::PayloadW-1:0] payload_q, payload_d;
  logic [pcf_pkg::ByteW-1:0]    orient_q, orient_d;
  logic [pcf_pkg::IndexW-1:0]   index_q, index_d;
  logic [pcf_pkg::PayloadW-1:0] fill_q, fill_d;
  logic [pcf_pkg::PayloadW-1:0] fill_inc;
  logic [pcf_pkg::PayloadW-1:0] cap_raw;
  logic [pcf_pkg::PayloadW-1:0] cap;
  logic                         index_zero;
  logic                         chunk_full;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign index_zero = (index_q == '0);
  assign fill_inc   = fill_q + pcf_pkg::PayloadW'(1);
  assign cap_raw    = (index_zero && payload_q != '0) ?
                      payload_q - pcf_pkg::PayloadW'(1) : payload_q;
  assign cap        = (cap_raw == '0) ? pcf_pkg::PayloadW'(1) : cap_raw;
  assign chunk_full = (fill_inc >= cap);

  always_comb begin
    push_job_o.index  = index_q;
    push_job_o.orient = orient_q;
    push_job_o.data   = data_byte_i;
    if (kind_i) begin
      push_job_o.kind = pcf_pkg::JOB_MARKER;
    end else if (fill_q != '0) begin
      push_job_o.kind = pcf_pkg::JOB_DATA;
    end else if (index_zero) begin
      push_job_o.kind = pcf_pkg::JOB_HDR_ORIENT;
    end else begin
      push_job_o.kind = pcf_pkg::JOB_HDR;
    end
  end

  always_comb begin
    index_d = index_q;
    fill_d  = fill_q;
    if (push_o) begin
      if (kind_i) begin
        index_d = '0;
        fill_d  = '0;
      end else if (chunk_full) begin
        index_d = index_q + pcf_pkg::IndexW'(1);
        fill_d  = '0;
      end else begin
        fill_d = fill_inc;
      end
    end
  end

  always_comb begin
    payload_d = payload_q;
    orient_d  = orient_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pcf_pkg::CfgChunkPayload: payload_d = cfg_data_i;
        pcf_pkg::CfgOrientation:  orient_d  = cfg_data_i[pcf_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q <= pcf_pkg::PayloadReset;
      orient_q  <= pcf_pkg::OrientReset;
      index_q   <= '0;
      fill_q    <= '0;
    end else begin
      payload_q <= payload_d;
      orient_q  <= orient_d;
      index_q   <= index_d;
      fill_q    <= fill_d;
    end
  end

endmodule

// ===== rtl/pcf_queue.sv =====
// pcf_queue: short job queue between front and back
// register-based ring of pcf_pkg::job_t entries; uses pcf_pkg
`timescale 1ns / 1ps

module pcf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcf_pkg::job_t push_job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output pcf_pkg::job_t head_o
);

  pcf_pkg::job_t                 entry_q [pcf_pkg::QueueDepth];
  logic [pcf_pkg::QueueAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [pcf_pkg::QueueAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [pcf_pkg::QueueCntW-1:0] count_q, count_d;
  logic                          do_pop;

  assign full_o  = (count_q == pcf_pkg::QueueCntW'(pcf_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + pcf_pkg::QueueAw'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + pcf_pkg::QueueAw'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + pcf_pkg::QueueCntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - pcf_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/pcf_back.sv =====
// pcf_back: expands each queued job into stream bytes, one per cycle while the output
// is not stalled, through a registered output stage; uses pcf_pkg
`timescale 1ns / 1ps

module pcf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  pcf_pkg::job_t             q_head_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pcf_pkg::out_beat_t        out_beat_o
);

  logic [pcf_pkg::StepW-1:0] step_q, step_d;
  logic                      valid_q, valid_d;
  pcf_pkg::out_beat_t        beat_q, beat;
  logic                      load;

  assign load        = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o     = load && beat.run_last;
  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

  always_comb begin
    beat.out_byte    = q_head_i.data;
    beat.chunk_start = 1'b0;
    beat.is_marker   = 1'b0;
    beat.run_last    = 1'b0;
    case (q_head_i.kind)
      pcf_pkg::JOB_MARKER: begin
        beat.out_byte    = pcf_pkg::MarkerByte;
        beat.is_marker   = 1'b1;
        beat.chunk_start = (step_q == 2'd0);
        beat.run_last    = (step_q != 2'd0);
      end
      pcf_pkg::JOB_HDR: begin
        case (step_q)
          2'd0: begin
            beat.out_byte    = q_head_i.index[7:0];
            beat.chunk_start = 1'b1;
          end
          2'd1: beat.out_byte = q_head_i.index[15:8];
          default: beat.run_last = 1'b1;
        endcase
      end
      pcf_pkg::JOB_HDR_ORIENT: begin
        case (step_q)
          2'd0: begin
            beat.out_byte    = q_head_i.index[7:0];
            beat.chunk_start = 1'b1;
          end
          2'd1: beat.out_byte = q_head_i.index[15:8];
          2'd2: beat.out_byte = q_head_i.orient;
          default: beat.run_last = 1'b1;
        endcase
      end
      pcf_pkg::JOB_DATA: beat.run_last = 1'b1;
      default: beat.run_last = 1'b1;
    endcase
  end

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      step_d  = beat.run_last ? '0 : step_q + pcf_pkg::StepW'(1);
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for photo_chunk_framer, predicts the framed byte stream
// drives random idling on both channels and checks every output transaction
// depends on pcf_pkg and the rtl top level photo_chunk_framer
`timescale 1ns / 1ps

module tb_top;
  import pcf_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 80;
  localparam logic        KindData     = 1'b0;
  localparam logic        KindEnd      = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                kind_i      = 1'b0;
  logic [ByteW-1:0]    data_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ByteW-1:0]    out_byte_o;
  logic                chunk_start_o;
  logic                is_marker_o;
  logic                run_last_o;

  // framing state mirrored from the block
  logic [PayloadW-1:0] frm_payload = PayloadReset;
  logic [ByteW-1:0]    frm_orient  = OrientReset;
  logic [IndexW-1:0]   frm_index   = '0;
  logic [PayloadW-1:0] frm_fill    = '0;

  out_beat_t   framed_bytes[$];
  int unsigned fault_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_gaps      = 1'b1;
  bit          rx_gaps      = 1'b1;
  bit          hold_req     = 1'b0;

  photo_chunk_framer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .chunk_start_o (chunk_start_o),
    .is_marker_o   (is_marker_o),
    .run_last_o    (run_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_beat_t stream_byte(input logic [ByteW-1:0] b, input logic start,
                                            input logic marker, input logic last);
    out_beat_t r;
    r.out_byte    = b;
    r.chunk_start = start;
    r.is_marker   = marker;
    r.run_last    = last;
    return r;
  endfunction

  task automatic frame_input(input logic kind, input logic [ByteW-1:0] data);
    logic [PayloadW-1:0] room;
    if (kind == KindEnd) begin
      framed_bytes.push_back(stream_byte(MarkerByte, 1'b1, 1'b1, 1'b0));
      framed_bytes.push_back(stream_byte(MarkerByte, 1'b0, 1'b1, 1'b1));
      frm_fill  = '0;
      frm_index = '0;
    end else begin
      if (frm_fill == '0) begin
        framed_bytes.push_back(stream_byte(frm_index[7:0], 1'b1, 1'b0, 1'b0));
        framed_bytes.push_back(stream_byte(frm_index[15:8], 1'b0, 1'b0, 1'b0));
        if (frm_index == '0) begin
          framed_bytes.push_back(stream_byte(frm_orient, 1'b0, 1'b0, 1'b0));
        end
      end
      framed_bytes.push_back(stream_byte(data, 1'b0, 1'b0, 1'b1));
      frm_fill = frm_fill + PayloadW'(1);
      room = frm_payload;
      if (frm_index == '0 && room != '0) begin
        room = room - PayloadW'(1);
      end
      if (room == '0) begin
        room = PayloadW'(1);
      end
      if (frm_fill >= room) begin
        frm_fill  = '0;
        frm_index = frm_index + IndexW'(1);
      end
    end
  endtask

  task automatic send_item(input logic kind, input logic [ByteW-1:0] data);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    data_byte_i <= data;
    @(posedge clk_i);
    while (!(in_valid_i && !in_stall_o)) @(posedge clk_i);
    frame_input(kind, data);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (framed_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgChunkPayload) begin
      frm_payload = value[PayloadW-1:0];
    end else if (idx == CfgOrientation) begin
      frm_orient = value[ByteW-1:0];
    end
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_item(KindData, 8'h00);
    send_item(KindData, 8'hFF);
    send_item(KindEnd, 8'h00);
    settle();
  endtask

  task automatic test_empty_photo();
    send_item(KindEnd, 8'hFF);
    settle();
  endtask

  task automatic test_tiny_payload();
    write_reg(CfgChunkPayload, 10'd0);
    send_item(KindData, 8'h01);
    send_item(KindData, 8'h80);
    settle();
    write_reg(CfgChunkPayload, 10'd1);
    send_item(KindData, 8'h7F);
    send_item(KindData, 8'hFE);
    send_item(KindEnd, 8'h3C);
    settle();
    write_reg(CfgChunkPayload, 10'd2);
    send_item(KindData, 8'h11);
    send_item(KindData, 8'h22);
    send_item(KindData, 8'h33);
    send_item(KindEnd, 8'hC3);
    settle();
  endtask

  task automatic test_register_writes();
    write_reg(CfgOrientation, 10'h3FF);
    write_reg(CfgSpareA, 10'h005);
    write_reg(CfgSpareB, 10'h3AA);
    send_item(KindData, 8'h55);
    send_item(KindEnd, 8'hAA);
    settle();
  endtask

  task automatic test_lowered_mid_chunk();
    write_reg(CfgChunkPayload, 10'd5);
    send_item(KindData, 8'h10);
    send_item(KindData, 8'h20);
    send_item(KindData, 8'h30);
    settle();
    write_reg(CfgChunkPayload, 10'd3);
    send_item(KindData, 8'h40);
    send_item(KindData, 8'h50);
    send_item(KindEnd, 8'h60);
    settle();
  endtask

  task automatic test_large_payload();
    write_reg(CfgChunkPayload, 10'd512);
    send_item(KindData, 8'hAA);
    send_item(KindData, 8'h33);
    settle();
    write_reg(CfgChunkPayload, 10'd1023);
    send_item(KindData, 8'h0F);
    send_item(KindEnd, 8'hF0);
    settle();
  endtask

  // receiver holds off while the sender streams, so the job queue fills
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    write_reg(CfgChunkPayload, 10'd3);
    write_reg(CfgOrientation, 10'h0A5);
    hold_req = 1'b1;
    repeat (24) send_item(KindData, ByteW'($urandom_range(0, 255)));
    send_item(KindEnd, ByteW'($urandom_range(0, 255)));
    settle();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < 175) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        write_reg(CfgChunkPayload, 10'd512);
      end else if (pick == 1) begin
        write_reg(CfgChunkPayload, CfgDataW'($urandom_range(0, 1)));
      end else begin
        write_reg(CfgChunkPayload, CfgDataW'($urandom_range(2, 12)));
      end
      write_reg(CfgOrientation, CfgDataW'($urandom_range(0, 1023)));
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      len = $urandom_range(0, 24);
      repeat (len) send_item(KindData, ByteW'($urandom_range(0, 255)));
      sent += len;
      if ($urandom_range(0, 4) != 0) begin
        send_item(KindEnd, ByteW'($urandom_range(0, 255)));
        sent++;
      end
      settle();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin : drain_output
    int unsigned pause;
    forever begin
      if (hold_req) begin
        pause    = HoldCycles;
        hold_req = 1'b0;
      end else begin
        pause = rx_gaps ? $urandom_range(0, 9) : 0;
      end
      if (pause != 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_stream
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (framed_bytes.size() == 0) begin
        $error("out_byte: expected nothing, got %02h", out_byte_o);
        fault_count++;
      end else begin
        want = framed_bytes.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte_o);
          fault_count++;
        end
        if (chunk_start_o !== want.chunk_start) begin
          $error("chunk_start: expected %0b, got %0b", want.chunk_start, chunk_start_o);
          fault_count++;
        end
        if (is_marker_o !== want.is_marker) begin
          $error("is_marker: expected %0b, got %0b", want.is_marker, is_marker_o);
          fault_count++;
        end
        if (run_last_o !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, run_last_o);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_empty_photo();
    test_tiny_payload();
    test_register_writes();
    test_lowered_mid_chunk();
    test_large_payload();
    test_backpressure();
    test_random_frames();
    if (fault_count == 0 && framed_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
